>>> rtl/core/pfst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page fetch status tracker package
// Request codes, page status codes, register indexes and field widths shared
// by the tracker, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package pfst_pkg;

  // Field widths of the request and result channels.
  localparam int MODE_W   = 2;
  localparam int PIDX_W   = 16;
  localparam int BYTES_W  = 21;
  localparam int RPAGE_W  = 12;
  localparam int ROFF_W   = 31;
  localparam int RLEN_W   = 20;
  localparam int STATE_W  = 2;
  localparam int COUNT_W  = 13;

  // Configuration register widths and port geometry.
  localparam int WORDS_W  = 17;
  localparam int PCOUNT_W = 13;
  localparam int CAP_W    = 13;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_PREFETCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FORCED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DISCARD  = 2'd3;

  // Page status codes.
  localparam logic [STATE_W-1:0] ST_INVALID   = 2'd0;
  localparam logic [STATE_W-1:0] ST_SHARED    = 2'd1;
  localparam logic [STATE_W-1:0] ST_FETCHING  = 2'd2;
  localparam logic [STATE_W-1:0] ST_TODISCARD = 2'd3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PAGE_WORDS = 2'd0;
  localparam logic [1:0] REG_PAGE_COUNT = 2'd1;
  localparam logic [1:0] REG_LAST_WORDS = 2'd2;
  localparam logic [1:0] REG_CAPACITY   = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  typedef logic [STATE_W-1:0] page_state_t;

endpackage

`default_nettype wire

>>> rtl/core/pfst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page fetch status tracker channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
interface pfst_req_if;
  logic                                valid;
  logic                                ready;
  logic [pfst_pkg::MODE_W-1:0]         mode;
  logic [pfst_pkg::PIDX_W-1:0]         page_index;
  logic signed [pfst_pkg::BYTES_W-1:0] bytes_read;

  modport source (output valid, output mode, output page_index, output bytes_read,
                  input ready);
  modport sink   (input valid, input mode, input page_index, input bytes_read,
                  output ready);
endinterface

interface pfst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          issue_read;
  logic [pfst_pkg::RPAGE_W-1:0]  read_page;
  logic [pfst_pkg::ROFF_W-1:0]   read_offset;
  logic [pfst_pkg::RLEN_W-1:0]   read_length;
  logic [pfst_pkg::STATE_W-1:0]  page_state;
  logic [pfst_pkg::COUNT_W-1:0]  resident_pages;
  logic                          length_error;

  modport source (output valid, output accepted, output issue_read, output read_page,
                  output read_offset, output read_length, output page_state,
                  output resident_pages, output length_error, input ready);
  modport sink   (input valid, input accepted, input issue_read, input read_page,
                  input read_offset, input read_length, input page_state,
                  input resident_pages, input length_error, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pfst_status_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page status store
// Synchronous page status memory with one read and one write port, and a
// clearing pass after reset that writes every entry to invalid.
// ----------------------------------------------------------------------------
module pfst_status_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                rd_en,
  input  wire  [AW-1:0]                      rd_addr,
  output pfst_pkg::page_state_t              rd_data,
  input  wire                                wr_en,
  input  wire  [AW-1:0]                      wr_addr,
  input  wire  pfst_pkg::page_state_t        wr_data,
  output logic                               clearing
);

  pfst_pkg::page_state_t mem [DEPTH];
  pfst_pkg::page_state_t rd_data_r;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  clearing_r, clearing_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= pfst_pkg::ST_INVALID;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

`default_nettype wire

>>> rtl/core/page_fetch_status_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page fetch status tracker
// Two-bit status per page and a resident page count, updated by prefetch,
// forced prefetch, read completion and discard requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Carries
//  in_req    in         valid/ready         mode, page_index, bytes_read
//  out_rsp   out        valid/ready         one result per request
//  APB       in         psel/penable/pready four 32-bit registers
//
// One request per cycle is taken while the result is not stalled; its result passes
// through stage 1 (status read) and then the result register (modify and write
// back). A request to the page just written is served by forwarding.
// After reset the status memory is swept, each of its MAX_PAGES entries (4096 by
// default) being written to invalid, and no request is taken meanwhile. A stalled
// result holds stage 1, which in turn holds in_req.ready low.
module page_fetch_status_tracker #(
  parameter int MAX_PAGES      = 4096,
  parameter int MAX_PAGE_WORDS = 65536
) (
  input  wire                               clk,
  input  wire                               rst_n,
  pfst_req_if.sink                          in_req,
  pfst_rsp_if.source                        out_rsp,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [pfst_pkg::ADDR_W-1:0]       paddr,
  input  wire  [pfst_pkg::DATA_W-1:0]       pwdata,
  output logic [pfst_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW_W  = 21;       // clamped word count, up to 2^20
  localparam int LEN_W = CW_W + 3; // byte length
  localparam int PROD_W = pfst_pkg::PIDX_W + LEN_W;

  // Configuration registers.
  logic [pfst_pkg::WORDS_W-1:0]  page_words_r;
  logic [pfst_pkg::PCOUNT_W-1:0] page_count_r;
  logic [pfst_pkg::WORDS_W-1:0]  last_words_r;
  logic [pfst_pkg::CAP_W-1:0]    capacity_r;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_words_r <= 17'd512;
      page_count_r <= 13'd4096;
      last_words_r <= 17'd512;
      capacity_r   <= 13'd4096;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pfst_pkg::REG_PAGE_WORDS: page_words_r <= pwdata[pfst_pkg::WORDS_W-1:0];
        pfst_pkg::REG_PAGE_COUNT: page_count_r <= pwdata[pfst_pkg::PCOUNT_W-1:0];
        pfst_pkg::REG_LAST_WORDS: last_words_r <= pwdata[pfst_pkg::WORDS_W-1:0];
        pfst_pkg::REG_CAPACITY:   capacity_r   <= pwdata[pfst_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pfst_pkg::REG_PAGE_WORDS: prdata = pfst_pkg::DATA_W'(page_words_r);
      pfst_pkg::REG_PAGE_COUNT: prdata = pfst_pkg::DATA_W'(page_count_r);
      pfst_pkg::REG_LAST_WORDS: prdata = pfst_pkg::DATA_W'(last_words_r);
      pfst_pkg::REG_CAPACITY:   prdata = pfst_pkg::DATA_W'(capacity_r);
      default:                  prdata = '0;
    endcase
  end

  // Stage 1: request waiting for its status read.
  logic                                s1_valid_r, s1_valid_nxt;
  logic [pfst_pkg::MODE_W-1:0]         s1_mode_r;
  logic [pfst_pkg::PIDX_W-1:0]         s1_page_r;
  logic [pfst_pkg::BYTES_W-1:0]        s1_bytes_r;
  logic                                s1_fwd_r;
  pfst_pkg::page_state_t               s1_fwd_st_r;

  logic                                clearing;
  logic                                s1_fire;
  logic                                in_fire;
  logic                                out_valid_r, out_valid_nxt;
  pfst_pkg::page_state_t               rd_data;
  logic [pfst_pkg::COUNT_W-1:0]        count_r, count_nxt;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !clearing && (!s1_valid_r || s1_fire);
  assign in_fire      = in_req.valid && in_req.ready;

  // Page limit and range check.
  logic [31:0] limit;
  logic [31:0] page_ext;
  logic        in_range;
  logic        is_last;

  assign limit    = (32'(page_count_r) < 32'(MAX_PAGES)) ? 32'(page_count_r)
                                                         : 32'(MAX_PAGES);
  assign page_ext = 32'(s1_page_r);
  assign in_range = page_ext < limit;
  assign is_last  = page_ext == (limit - 32'd1);

  // Word counts saturate at MAX_PAGE_WORDS.
  logic [CW_W-1:0]   words_clamp, last_clamp;
  logic [LEN_W-1:0]  page_len, expect_len;
  logic [PROD_W-1:0] offset_full;

  assign words_clamp = (32'(page_words_r) > 32'(MAX_PAGE_WORDS)) ? CW_W'(MAX_PAGE_WORDS)
                                                                 : CW_W'(page_words_r);
  assign last_clamp  = (32'(last_words_r) > 32'(MAX_PAGE_WORDS)) ? CW_W'(MAX_PAGE_WORDS)
                                                                 : CW_W'(last_words_r);
  assign page_len    = {words_clamp, 3'b000};
  assign expect_len  = is_last ? {last_clamp, 3'b000} : page_len;
  assign offset_full = PROD_W'(s1_page_r) * PROD_W'(page_len);

  // Status update.
  pfst_pkg::page_state_t cur_st, new_st;
  logic                  acc, issue, len_err;
  logic                  cnt_up, cnt_down;

  assign cur_st = s1_fwd_r ? s1_fwd_st_r : rd_data;

  always_comb begin
    new_st   = cur_st;
    acc      = 1'b1;
    issue    = 1'b0;
    len_err  = 1'b0;
    cnt_up   = 1'b0;
    cnt_down = 1'b0;
    if (in_range) begin
      case (s1_mode_r)
        pfst_pkg::MODE_PREFETCH, pfst_pkg::MODE_FORCED: begin
          if (s1_mode_r == pfst_pkg::MODE_PREFETCH && count_r >= capacity_r) begin
            acc = 1'b0;
          end else if (cur_st == pfst_pkg::ST_TODISCARD) begin
            new_st = pfst_pkg::ST_FETCHING;
            cnt_up = 1'b1;
          end else if (cur_st == pfst_pkg::ST_INVALID) begin
            new_st = pfst_pkg::ST_FETCHING;
            cnt_up = 1'b1;
            issue  = 1'b1;
          end
        end
        pfst_pkg::MODE_COMPLETE: begin
          // A negative length has its top bit set, so it never matches either.
          if (s1_bytes_r[pfst_pkg::BYTES_W-1] ||
              LEN_W'(s1_bytes_r) != expect_len) begin
            len_err = 1'b1;
          end else if (cur_st == pfst_pkg::ST_TODISCARD) begin
            new_st = pfst_pkg::ST_INVALID;
          end else if (cur_st == pfst_pkg::ST_FETCHING) begin
            new_st = pfst_pkg::ST_SHARED;
          end
        end
        pfst_pkg::MODE_DISCARD: begin
          if (cur_st == pfst_pkg::ST_SHARED) begin
            new_st   = pfst_pkg::ST_INVALID;
            cnt_down = 1'b1;
          end else if (cur_st == pfst_pkg::ST_FETCHING) begin
            new_st   = pfst_pkg::ST_TODISCARD;
            cnt_down = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (s1_fire) begin
      if (cnt_up && count_r != pfst_pkg::COUNT_MAX) begin
        count_nxt = count_r + 13'd1;
      end else if (cnt_down && count_r != '0) begin
        count_nxt = count_r - 13'd1;
      end
    end
  end

  logic wr_en;
  assign wr_en = s1_fire && in_range;

  pfst_status_store #(
    .DEPTH (MAX_PAGES),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (AW'(in_req.page_index)),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (AW'(s1_page_r)),
    .wr_data  (new_st),
    .clearing (clearing)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // The memory read at acceptance misses a write-back to the same page made
  // on that same edge, so the new status is carried along instead.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= in_req.mode;
      s1_page_r   <= in_req.page_index;
      s1_bytes_r  <= in_req.bytes_read;
      s1_fwd_r    <= wr_en && (s1_page_r == in_req.page_index);
      s1_fwd_st_r <= new_st;
    end
  end

  logic                          acc_r, issue_r, err_r;
  logic [pfst_pkg::RPAGE_W-1:0]  rpage_r;
  logic [pfst_pkg::ROFF_W-1:0]   roff_r;
  logic [pfst_pkg::RLEN_W-1:0]   rlen_r;
  pfst_pkg::page_state_t         pstate_r;
  logic [pfst_pkg::COUNT_W-1:0]  rcount_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      acc_r    <= acc;
      issue_r  <= issue;
      err_r    <= len_err;
      rpage_r  <= issue ? s1_page_r[pfst_pkg::RPAGE_W-1:0] : '0;
      roff_r   <= issue ? offset_full[pfst_pkg::ROFF_W-1:0] : '0;
      rlen_r   <= issue ? page_len[pfst_pkg::RLEN_W-1:0] : '0;
      pstate_r <= in_range ? new_st : pfst_pkg::ST_INVALID;
      rcount_r <= count_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.accepted       = acc_r;
  assign out_rsp.issue_read     = issue_r;
  assign out_rsp.read_page      = rpage_r;
  assign out_rsp.read_offset    = roff_r;
  assign out_rsp.read_length    = rlen_r;
  assign out_rsp.page_state     = pstate_r;
  assign out_rsp.resident_pages = rcount_r;
  assign out_rsp.length_error   = err_r;

endmodule

`default_nettype wire

>>> rtl/core/pfst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page fetch status tracker checker
// Port-level assertions on the tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
module pfst_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire                               accepted,
  input wire                               issue_read,
  input wire [pfst_pkg::RPAGE_W-1:0]       read_page,
  input wire [pfst_pkg::ROFF_W-1:0]        read_offset,
  input wire [pfst_pkg::RLEN_W-1:0]        read_length,
  input wire [pfst_pkg::STATE_W-1:0]       page_state,
  input wire                               length_error
);

  // The status sweep after reset keeps requests out.
  a_no_req_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_idle_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !issue_read |->
      read_page == '0 && read_offset == '0 && read_length == '0)
    else $error("read fields set without a read");

  a_issue_fetching: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && issue_read |->
      accepted && !length_error && page_state == pfst_pkg::ST_FETCHING)
    else $error("read issued for a page not left fetching");

endmodule

bind page_fetch_status_tracker pfst_checker u_pfst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .accepted     (out_rsp.accepted),
  .issue_read   (out_rsp.issue_read),
  .read_page    (out_rsp.read_page),
  .read_offset  (out_rsp.read_offset),
  .read_length  (out_rsp.read_length),
  .page_state   (out_rsp.page_state),
  .length_error (out_rsp.length_error)
);

`default_nettype wire
